[rtl/core/miamd_pkg.sv]
package miamd_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CmdWidth  = 5;
  localparam int unsigned DivStages = DataWidth;

  typedef enum logic [CmdWidth-1:0] {
    CMD_NOP      = 5'd0,
    CMD_ADD_TRAP = 5'd1,
    CMD_ADD      = 5'd2,
    CMD_SUB_TRAP = 5'd3,
    CMD_SUB      = 5'd4,
    CMD_AND      = 5'd5,
    CMD_OR       = 5'd6,
    CMD_XOR      = 5'd7,
    CMD_SHL      = 5'd8,
    CMD_SHR_L    = 5'd9,
    CMD_SHR_A    = 5'd10,
    CMD_MUL      = 5'd11,
    CMD_MULU     = 5'd12,
    CMD_DIV      = 5'd13,
    CMD_DIVU     = 5'd14,
    CMD_CMP_EQ   = 5'd15,
    CMD_CMP_NE   = 5'd16,
    CMD_CMP_LT   = 5'd17,
    CMD_CMP_LTU  = 5'd18,
    CMD_CMP_LE   = 5'd19,
    CMD_CMP_GT   = 5'd20,
    CMD_CMP_GE   = 5'd21
  } cmd_e;

  // word carried down the pipeline; rem/dvd hold the product or the
  // partial remainder and the dividend/quotient shift register
  typedef struct packed {
    logic                 is_div;
    logic                 hl;
    logic                 neg_q;
    logic                 neg_r;
    logic                 ovf;
    logic [DataWidth-1:0] res;
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] dvd;
    logic [DataWidth-1:0] dvs;
  } pipe_t;

endpackage

[rtl/core/mips_integer_alu_mult_div.sv]
// Integer execute unit: add/subtract (plain and trapping), logic, shifts,
// compares, 32x32 multiply and 32/32 divide, fully pipelined. A word is taken
// on every clock edge where start_i is high; busy_o is always low because
// every stage advances each cycle. Each word comes out on done_o for exactly
// one cycle, in order, after passing through the registers in turn: the input
// register loads on the edge that took it, then come operand prep and multiply,
// 32 one-bit restoring divide stages and the sign fixup register. The
// receiver cannot stall the unit, so it must take every done_o word.
// Divide by zero yields hi = dividend and lo = all ones (or 1 for a negative
// signed dividend); signed min over minus one yields lo = 0x80000000, hi = 0.
module mips_integer_alu_mult_div
  import miamd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CmdWidth-1:0]  command_i,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] result_o,
  output logic [DataWidth-1:0] hi_word_o,
  output logic [DataWidth-1:0] lo_word_o,
  output logic                 writes_hi_lo_o,
  output logic                 overflow_trap_o
);

  localparam int unsigned ShW = $clog2(DataWidth);

  // never stalls
  assign busy_o = 1'b0;

  // input register
  logic                 in_vld_q;
  logic [CmdWidth-1:0]  cmd_q;
  logic [DataWidth-1:0] a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= command_i;
    a_q   <= operand_a_i;
    b_q   <= operand_b_i;
  end

  // prep stage: ALU ops, multiply, divide operand setup
  pipe_t                  prep_d;
  logic [DataWidth-1:0]   sum, diff;
  logic [ShW-1:0]         sh;
  logic                   slt_ab, slt_ba, mul_sgn, div_sgn;
  logic [2*DataWidth+1:0] prod;

  always_comb begin
    sum     = a_q + b_q;
    diff    = a_q - b_q;
    sh      = b_q[ShW-1:0];
    slt_ab  = $signed(a_q) < $signed(b_q);
    slt_ba  = $signed(b_q) < $signed(a_q);
    mul_sgn = (cmd_q == CMD_MUL);
    div_sgn = (cmd_q == CMD_DIV);
    prod    = $signed({mul_sgn & a_q[DataWidth-1], a_q})
            * $signed({mul_sgn & b_q[DataWidth-1], b_q});
    prep_d  = '0;
    unique case (cmd_q) inside
      CMD_ADD_TRAP: begin
        prep_d.res = sum;
        prep_d.ovf = ~(a_q[DataWidth-1] ^ b_q[DataWidth-1])
                   & (a_q[DataWidth-1] ^ sum[DataWidth-1]);
      end
      CMD_ADD:      prep_d.res = sum;
      CMD_SUB_TRAP: begin
        prep_d.res = diff;
        prep_d.ovf = (a_q[DataWidth-1] ^ b_q[DataWidth-1])
                   & (a_q[DataWidth-1] ^ diff[DataWidth-1]);
      end
      CMD_SUB:      prep_d.res = diff;
      CMD_AND:      prep_d.res = a_q & b_q;
      CMD_OR:       prep_d.res = a_q | b_q;
      CMD_XOR:      prep_d.res = a_q ^ b_q;
      CMD_SHL:      prep_d.res = a_q << sh;
      CMD_SHR_L:    prep_d.res = a_q >> sh;
      CMD_SHR_A:    prep_d.res = $unsigned($signed(a_q) >>> sh);
      CMD_MUL, CMD_MULU: begin
        prep_d.hl  = 1'b1;
        prep_d.rem = prod[2*DataWidth-1:DataWidth];
        prep_d.dvd = prod[DataWidth-1:0];
      end
      CMD_DIV, CMD_DIVU: begin
        // divide magnitudes, fix signs at the end
        prep_d.hl     = 1'b1;
        prep_d.is_div = 1'b1;
        prep_d.neg_q  = div_sgn & (a_q[DataWidth-1] ^ b_q[DataWidth-1]);
        prep_d.neg_r  = div_sgn & a_q[DataWidth-1];
        prep_d.dvd    = (div_sgn && a_q[DataWidth-1]) ? (~a_q + 1'b1) : a_q;
        prep_d.dvs    = (div_sgn && b_q[DataWidth-1]) ? (~b_q + 1'b1) : b_q;
      end
      CMD_CMP_EQ:   prep_d.res = DataWidth'(a_q == b_q);
      CMD_CMP_NE:   prep_d.res = DataWidth'(a_q != b_q);
      CMD_CMP_LT:   prep_d.res = DataWidth'(slt_ab);
      CMD_CMP_LTU:  prep_d.res = DataWidth'(a_q < b_q);
      CMD_CMP_LE:   prep_d.res = DataWidth'(!slt_ba);
      CMD_CMP_GT:   prep_d.res = DataWidth'(slt_ba);
      CMD_CMP_GE:   prep_d.res = DataWidth'(!slt_ab);
      default:      prep_d = '0;
    endcase
  end

  // stage 0 is the prep register, stages 1..DivStages each retire one
  // quotient bit
  pipe_t                st_q   [DivStages+1];
  logic [DivStages:0]   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DivStages-1:0], in_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= prep_d;
  end

  for (genvar i = 1; i <= DivStages; i++) begin : g_div
    pipe_t                st_d;
    logic [DataWidth+1:0] trial;

    always_comb begin
      st_d  = st_q[i-1];
      trial = {1'b0, st_q[i-1].rem, st_q[i-1].dvd[DataWidth-1]}
            - {2'b00, st_q[i-1].dvs};
      if (st_q[i-1].is_div) begin
        if (!trial[DataWidth+1]) begin
          st_d.rem = trial[DataWidth-1:0];
          st_d.dvd = {st_q[i-1].dvd[DataWidth-2:0], 1'b1};
        end else begin
          st_d.rem = {st_q[i-1].rem[DataWidth-2:0], st_q[i-1].dvd[DataWidth-1]};
          st_d.dvd = {st_q[i-1].dvd[DataWidth-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[i] <= st_d;
    end
  end

  // output register: sign fixup for signed divide
  pipe_t                last;
  logic                 done_q;
  logic [DataWidth-1:0] res_q, hi_q, lo_q;
  logic                 hl_q, ovf_q;

  assign last = st_q[DivStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= last.res;
    hl_q  <= last.hl;
    ovf_q <= last.ovf;
    hi_q  <= last.neg_r ? (~last.rem + 1'b1) : last.rem;
    lo_q  <= last.neg_q ? (~last.dvd + 1'b1) : last.dvd;
  end

  assign done_o          = done_q;
  assign result_o        = res_q;
  assign hi_word_o       = hi_q;
  assign lo_word_o       = lo_q;
  assign writes_hi_lo_o  = hl_q;
  assign overflow_trap_o = ovf_q;

endmodule

[tb/mips_integer_alu_mult_div_tb.sv]
module mips_integer_alu_mult_div_tb;
  import miamd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected word from the execute unit
  typedef struct {
    logic [DataWidth-1:0] result;
    logic [DataWidth-1:0] hi_word;
    logic [DataWidth-1:0] lo_word;
    logic                 writes_hi_lo;
    logic                 overflow_trap;
  } alu_word_t;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 60;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [CmdWidth-1:0]  command_i;
  logic [DataWidth-1:0] operand_a_i;
  logic [DataWidth-1:0] operand_b_i;
  logic                 done_o;
  logic [DataWidth-1:0] result_o;
  logic [DataWidth-1:0] hi_word_o;
  logic [DataWidth-1:0] lo_word_o;
  logic                 writes_hi_lo_o;
  logic                 overflow_trap_o;

  alu_word_t   expected_words[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned sender_idle_pct;

  mips_integer_alu_mult_div u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .done_o         (done_o),
    .result_o       (result_o),
    .hi_word_o      (hi_word_o),
    .lo_word_o      (lo_word_o),
    .writes_hi_lo_o (writes_hi_lo_o),
    .overflow_trap_o(overflow_trap_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Compute what the execute unit must return for one command word.
  function automatic alu_word_t compute_alu_word(logic [CmdWidth-1:0] cmd,
                                                 logic [DataWidth-1:0] a,
                                                 logic [DataWidth-1:0] b);
    alu_word_t w;
    logic [4:0] sh;
    logic [63:0] prod;
    logic signed [DataWidth-1:0] sa;
    logic signed [DataWidth-1:0] sb;
    logic [DataWidth-1:0] ua;
    logic [DataWidth-1:0] ub;
    logic [DataWidth-1:0] q;
    logic [DataWidth-1:0] r;
    w = '{default: '0};
    sh = b[4:0];
    sa = a;
    sb = b;
    case (cmd)
      CMD_ADD_TRAP: begin
        w.result = a + b;
        w.overflow_trap = ~(a[31] ^ b[31]) & (a[31] ^ w.result[31]);
      end
      CMD_ADD: w.result = a + b;
      CMD_SUB_TRAP: begin
        w.result = a - b;
        w.overflow_trap = (a[31] ^ b[31]) & (a[31] ^ w.result[31]);
      end
      CMD_SUB:   w.result = a - b;
      CMD_AND:   w.result = a & b;
      CMD_OR:    w.result = a | b;
      CMD_XOR:   w.result = a ^ b;
      CMD_SHL:   w.result = a << sh;
      CMD_SHR_L: w.result = a >> sh;
      CMD_SHR_A: w.result = sa >>> sh;
      CMD_MUL: begin
        w.writes_hi_lo = 1'b1;
        prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
        w.hi_word = prod[63:32];
        w.lo_word = prod[31:0];
      end
      CMD_MULU: begin
        w.writes_hi_lo = 1'b1;
        prod = {32'd0, a} * {32'd0, b};
        w.hi_word = prod[63:32];
        w.lo_word = prod[31:0];
      end
      CMD_DIV: begin
        w.writes_hi_lo = 1'b1;
        if (b == '0) begin
          w.hi_word = a;
          w.lo_word = a[31] ? 32'd1 : 32'hFFFF_FFFF;
        end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
          w.lo_word = 32'h8000_0000;
        end else begin
          ua = a[31] ? -a : a;
          ub = b[31] ? -b : b;
          q = ua / ub;
          r = ua % ub;
          w.lo_word = (a[31] ^ b[31]) ? -q : q;
          w.hi_word = a[31] ? -r : r;
        end
      end
      CMD_DIVU: begin
        w.writes_hi_lo = 1'b1;
        if (b == '0) begin
          w.hi_word = a;
          w.lo_word = 32'hFFFF_FFFF;
        end else begin
          w.lo_word = a / b;
          w.hi_word = a % b;
        end
      end
      CMD_CMP_EQ:  w.result = 32'(a == b);
      CMD_CMP_NE:  w.result = 32'(a != b);
      CMD_CMP_LT:  w.result = 32'(sa < sb);
      CMD_CMP_LTU: w.result = 32'(a < b);
      CMD_CMP_LE:  w.result = 32'(sa <= sb);
      CMD_CMP_GT:  w.result = 32'(sa > sb);
      CMD_CMP_GE:  w.result = 32'(sa >= sb);
      default: ;
    endcase
    return w;
  endfunction

  // Send one command word; hold it until the unit takes it. Return at the
  // next falling edge with start still high, so back-to-back words leave
  // no gap; the caller drops start once nothing more is sent.
  task automatic send_word(logic [CmdWidth-1:0] cmd, logic [DataWidth-1:0] a,
                           logic [DataWidth-1:0] b);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    command_i   <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_words.push_back(compute_alu_word(cmd, a, b));
    @(negedge clk_i);
  endtask

  // Check each done word against the oldest expectation.
  always @(posedge clk_i) begin
    alu_word_t exp_w;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: result=%h", result_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (result_o !== exp_w.result || hi_word_o !== exp_w.hi_word ||
            lo_word_o !== exp_w.lo_word || writes_hi_lo_o !== exp_w.writes_hi_lo ||
            overflow_trap_o !== exp_w.overflow_trap) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp res=%h hi=%h lo=%h hl=%b ov=%b",
                      " got res=%h hi=%h lo=%h hl=%b ov=%b"},
                     exp_w.result, exp_w.hi_word, exp_w.lo_word, exp_w.writes_hi_lo,
                     exp_w.overflow_trap, result_o, hi_word_o, lo_word_o,
                     writes_hi_lo_o, overflow_trap_o);
        end
      end
    end
  end

  // Watchdog: count cycles where no word moves either way.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("mips_integer_alu_mult_div regression: fail");
      $finish;
    end
  end

  function automatic logic [DataWidth-1:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(9));
      5: return -32'($urandom_range(9));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_ADD_TRAP, 32'h7FFF_FFFF, 32'h1);
    send_word(CMD_ADD_TRAP, 32'h8000_0000, 32'h8000_0000);
    send_word(CMD_ADD, 32'hFFFF_FFFF, 32'h1);
    send_word(CMD_SUB_TRAP, 32'h8000_0000, 32'h1);
    send_word(CMD_SUB_TRAP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_SUB, 32'h0, 32'h1);
    send_word(CMD_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_word(CMD_OR, 32'h0F0F_0000, 32'h0000_F0F0);
    send_word(CMD_XOR, 32'hFFFF_FFFF, 32'h1234_5678);
    // shift amounts above 31 use only the low five bits
    send_word(CMD_SHL, 32'h1, 32'hFFFF_FFFF);
    send_word(CMD_SHR_L, 32'h8000_0000, 32'h21);
    send_word(CMD_SHR_A, 32'h8000_0000, 32'h1F);
    send_word(CMD_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_MULU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_DIV, 32'hFFFF_FFF9, 32'h0);
    send_word(CMD_DIV, 32'h7, 32'h0);
    send_word(CMD_DIV, 32'hFFFF_FFF9, 32'h2);
    send_word(CMD_DIVU, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_CMP_EQ, 32'h5, 32'h5);
    send_word(CMD_CMP_NE, 32'h5, 32'h5);
    send_word(CMD_CMP_LT, 32'h8000_0000, 32'h1);
    send_word(CMD_CMP_LTU, 32'h8000_0000, 32'h1);
    send_word(CMD_CMP_LE, 32'h3, 32'h3);
    send_word(CMD_CMP_GT, 32'h1, 32'hFFFF_FFFF);
    send_word(CMD_CMP_GE, 32'hFFFF_FFFF, 32'h1);
    send_word(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Random words at a given sender idle rate; mostly valid commands.
  task automatic test_random(int unsigned count, int unsigned idle_pct);
    logic [CmdWidth-1:0] cmd;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      if ($urandom_range(19) == 0) cmd = 5'($urandom_range(31, 22));
      else cmd = 5'($urandom_range(21));
      send_word(cmd, pick_operand(), pick_operand());
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    mismatches      = 0;
    idle_cycles     = 0;
    sender_idle_pct = 0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    command_i       = '0;
    operand_a_i     = '0;
    operand_b_i     = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(500, 0);
    test_random(500, 77);
    test_random(450, 0);
    test_random(500, 21);
    start_i <= 1'b0;

    // drain: wait for every word, then wait on so that any stray word shows up
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) $display("mips_integer_alu_mult_div regression: pass");
    else $display("mips_integer_alu_mult_div regression: fail");
    $finish;
  end

endmodule
